/* hw/rtl/bgtr_pkg.sv */
// shared types, constants and the character to glyph mapping of the text renderer
// no dependencies
package bgtr_pkg;

    localparam int COORD_W    = 11;
    localparam int DIM_W      = 10;
    localparam int ADDR_W     = 17;
    localparam int COLOR_W    = 16;
    localparam int CODE_W     = 8;
    localparam int GLYPH_W    = 6;
    localparam int ROM_AW     = 9;
    localparam int ROM_DEPTH  = 260;
    localparam int OFF_W      = 3;

    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 8;
    localparam int CURSOR_STEP = 6;
    localparam int DIGIT_BASE  = 16;
    localparam int ALPHA_BASE  = 26;
    localparam int CURSOR_MAX  = 1023;

    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 240;

    localparam logic [CODE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CODE_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CODE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CODE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CODE_W-1:0] CHAR_UPA   = 8'h41;
    localparam logic [CODE_W-1:0] CHAR_UPZ   = 8'h5A;

    // one glyph job handed from the setup register to the walker
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [ROM_AW-1:0]         gbase;
        logic [COLOR_W-1:0]        fg;
        logic [COLOR_W-1:0]        bg;
    } t_setup;

    // unmapped codes fall back to the space glyph
    function automatic logic [GLYPH_W-1:0] glyph_number(input logic [CODE_W-1:0] code);
        logic [GLYPH_W-1:0] num;
        num = '0;
        if (code >= CHAR_SPACE && code <= CHAR_SLASH) begin
            num = GLYPH_W'(code - CHAR_SPACE);
        end else if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            num = GLYPH_W'(DIGIT_BASE) + GLYPH_W'(code - CHAR_ZERO);
        end else if (code >= CHAR_UPA && code <= CHAR_UPZ) begin
            num = GLYPH_W'(ALPHA_BASE) + GLYPH_W'(code - CHAR_UPA);
        end
        return num;
    endfunction

endpackage

/* hw/rtl/bgtr_font_rom.sv */
// 5x8 column font memory, one byte per glyph column, registered read
// depends on bgtr_pkg
module bgtr_font_rom
    import bgtr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ROM_AW-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    localparam logic [7:0] FONT [0:ROM_DEPTH-1] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,
        8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
        8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
        8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00,
        8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,
        8'h14,8'h08,8'h3E,8'h08,8'h14, 8'h08,8'h08,8'h3E,8'h08,8'h08,
        8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
        8'h00,8'h60,8'h60,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
        8'h1C,8'h22,8'h22,8'h22,8'h1C, 8'h08,8'h18,8'h08,8'h08,8'h08,
        8'h1C,8'h22,8'h10,8'h08,8'h3E, 8'h3E,8'h10,8'h18,8'h04,8'h3C,
        8'h08,8'h14,8'h22,8'h3E,8'h08, 8'h3E,8'h20,8'h3C,8'h02,8'h3C,
        8'h1C,8'h20,8'h3C,8'h22,8'h1C, 8'h3E,8'h02,8'h04,8'h08,8'h10,
        8'h1C,8'h22,8'h1C,8'h22,8'h1C, 8'h1C,8'h22,8'h1E,8'h02,8'h1C,
        8'h1C,8'h22,8'h3E,8'h22,8'h22, 8'h3C,8'h22,8'h3C,8'h22,8'h3C,
        8'h1C,8'h22,8'h20,8'h22,8'h1C, 8'h3C,8'h22,8'h22,8'h22,8'h3C,
        8'h3E,8'h20,8'h38,8'h20,8'h3E, 8'h3E,8'h20,8'h38,8'h20,8'h20,
        8'h1C,8'h20,8'h2E,8'h22,8'h1C, 8'h22,8'h22,8'h3E,8'h22,8'h22,
        8'h1C,8'h08,8'h08,8'h08,8'h1C, 8'h0E,8'h02,8'h02,8'h22,8'h1C,
        8'h22,8'h28,8'h30,8'h28,8'h22, 8'h20,8'h20,8'h20,8'h20,8'h3E,
        8'h22,8'h36,8'h2A,8'h22,8'h22, 8'h22,8'h3A,8'h2A,8'h26,8'h22,
        8'h1C,8'h22,8'h22,8'h22,8'h1C, 8'h3C,8'h22,8'h3C,8'h20,8'h20,
        8'h1C,8'h22,8'h22,8'h2A,8'h1C, 8'h3C,8'h22,8'h3C,8'h28,8'h24,
        8'h1E,8'h20,8'h1C,8'h02,8'h3C, 8'h3E,8'h08,8'h08,8'h08,8'h08,
        8'h22,8'h22,8'h22,8'h22,8'h1C, 8'h22,8'h22,8'h22,8'h14,8'h08,
        8'h22,8'h22,8'h2A,8'h2A,8'h14, 8'h22,8'h14,8'h08,8'h14,8'h22,
        8'h22,8'h14,8'h08,8'h08,8'h10, 8'h3E,8'h04,8'h08,8'h10,8'h3E
    };

    logic [7:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= FONT[i_rd_addr];
        end
    end

    assign o_rd_data = r_data;

endmodule

/* hw/rtl/bgtr_pixel_walker.sv */
// clips a glyph job to the screen and walks its visible pixels, one write per cycle
// unless stalled; depends on bgtr_pkg; reads column bytes via the font memory port
module bgtr_pixel_walker
    import bgtr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  t_setup             i_job,
    output logic               o_job_take,
    output logic               o_rom_en,
    output logic [ROM_AW-1:0]  o_rom_addr,
    input  logic [7:0]         i_rom_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [ADDR_W-1:0]  o_pixel_address,
    output logic [COLOR_W-1:0] o_pixel_color,
    output logic               o_last_pixel
);

    localparam logic signed [COORD_W:0] W_MAX   = (COORD_W+1)'(SCREEN_WIDTH - 1);
    localparam logic signed [COORD_W:0] H_MAX   = (COORD_W+1)'(SCREEN_HEIGHT - 1);
    localparam logic signed [COORD_W:0] COL_SPAN = (COORD_W+1)'(GLYPH_COLS - 1);
    localparam logic signed [COORD_W:0] ROW_SPAN = (COORD_W+1)'(GLYPH_ROWS - 1);
    localparam logic [ADDR_W-1:0]       ADDR_STEP = ADDR_W'(SCREEN_WIDTH);

    // clip of the waiting job
    logic signed [COORD_W:0] cx_e, cy_e, w_rem, h_rem;
    logic                    vis;
    logic [OFF_W-1:0]        c_lo, c_hi, r_lo_c, r_hi_c;
    logic [DIM_W-1:0]        col_start, row_start;
    logic [2*DIM_W-1:0]      row_prod;
    logic [ADDR_W-1:0]       base_addr;

    always_comb begin
        cx_e  = {i_job.cx[COORD_W-1], i_job.cx};
        cy_e  = {i_job.cy[COORD_W-1], i_job.cy};
        vis   = (cx_e <= W_MAX) && (cx_e + COL_SPAN >= 0) &&
                (cy_e <= H_MAX) && (cy_e + ROW_SPAN >= 0);
        w_rem = W_MAX - cx_e;
        h_rem = H_MAX - cy_e;
        c_lo   = (cx_e < 0) ? OFF_W'(-cx_e) : '0;
        r_lo_c = (cy_e < 0) ? OFF_W'(-cy_e) : '0;
        c_hi   = (w_rem > COL_SPAN) ? OFF_W'(GLYPH_COLS - 1) : OFF_W'(w_rem);
        r_hi_c = (h_rem > ROW_SPAN) ? OFF_W'(GLYPH_ROWS - 1) : OFF_W'(h_rem);
        col_start = DIM_W'(cx_e + (COORD_W+1)'(c_lo));
        row_start = DIM_W'(cy_e + (COORD_W+1)'(r_lo_c));
        row_prod  = (2*DIM_W)'(row_start) * (2*DIM_W)'(SCREEN_WIDTH);
        base_addr = ADDR_W'(row_prod) + ADDR_W'(col_start);
    end

    // walk state
    logic                r_g_valid, n_g_valid;
    logic [OFF_W-1:0]    r_col, n_col, r_col_hi, n_col_hi;
    logic [OFF_W-1:0]    r_row, n_row, r_row_lo, n_row_lo, r_row_hi, n_row_hi;
    logic [ADDR_W-1:0]   r_addr, n_addr, r_col_addr, n_col_addr;
    logic [ROM_AW-1:0]   r_gbase, n_gbase;
    logic [COLOR_W-1:0]  r_fg, n_fg, r_bg, n_bg;
    logic                g_last, adv;

    // output word
    logic                r_o_valid;
    logic [ADDR_W-1:0]   r_o_addr;
    logic [OFF_W-1:0]    r_o_row;
    logic [COLOR_W-1:0]  r_o_fg, r_o_bg;
    logic                r_o_last;

    assign g_last     = (r_col == r_col_hi) && (r_row == r_row_hi);
    assign adv        = r_g_valid && (!r_o_valid || i_out_ready);
    assign o_job_take = i_job_valid && (!r_g_valid || (adv && g_last));
    assign o_rom_en   = adv;
    assign o_rom_addr = r_gbase + ROM_AW'(r_col);

    always_comb begin
        n_g_valid  = r_g_valid;
        n_col      = r_col;
        n_col_hi   = r_col_hi;
        n_row      = r_row;
        n_row_lo   = r_row_lo;
        n_row_hi   = r_row_hi;
        n_addr     = r_addr;
        n_col_addr = r_col_addr;
        n_gbase    = r_gbase;
        n_fg       = r_fg;
        n_bg       = r_bg;
        if (adv) begin
            if (g_last) begin
                n_g_valid = 1'b0;
            end else if (r_row != r_row_hi) begin
                n_row  = r_row + OFF_W'(1);
                n_addr = r_addr + ADDR_STEP;
            end else begin
                n_col      = r_col + OFF_W'(1);
                n_row      = r_row_lo;
                n_col_addr = r_col_addr + ADDR_W'(1);
                n_addr     = r_col_addr + ADDR_W'(1);
            end
        end
        // a fully clipped job is dropped without occupying the walker
        if (o_job_take) begin
            n_g_valid  = vis;
            n_col      = c_lo;
            n_col_hi   = c_hi;
            n_row      = r_lo_c;
            n_row_lo   = r_lo_c;
            n_row_hi   = r_hi_c;
            n_addr     = base_addr;
            n_col_addr = base_addr;
            n_gbase    = i_job.gbase;
            n_fg       = i_job.fg;
            n_bg       = i_job.bg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_g_valid <= n_g_valid;
            if (adv) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
        r_col      <= n_col;
        r_col_hi   <= n_col_hi;
        r_row      <= n_row;
        r_row_lo   <= n_row_lo;
        r_row_hi   <= n_row_hi;
        r_addr     <= n_addr;
        r_col_addr <= n_col_addr;
        r_gbase    <= n_gbase;
        r_fg       <= n_fg;
        r_bg       <= n_bg;
        if (adv) begin
            r_o_addr <= r_addr;
            r_o_row  <= r_row;
            r_o_fg   <= r_fg;
            r_o_bg   <= r_bg;
            r_o_last <= g_last;
        end
    end

    // column byte arrives with the word, bit r is row r from the top
    assign o_out_valid     = r_o_valid;
    assign o_pixel_address = r_o_addr;
    assign o_pixel_color   = i_rom_data[r_o_row] ? r_o_fg : r_o_bg;
    assign o_last_pixel    = r_o_last;

`ifndef ASSERT_OFF
    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_g_valid |-> (r_col <= r_col_hi) && (r_row >= r_row_lo) && (r_row <= r_row_hi)
                      && (r_col_hi <= OFF_W'(GLYPH_COLS - 1)))
        else $error("walker position outside its clip window");

    a_rom_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |-> (32'(o_rom_addr) < ROM_DEPTH))
        else $error("font read beyond the glyph table");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && g_last && !o_job_take) |=> !r_g_valid)
        else $error("walker kept running after the last pixel");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_out_ready) |-> !adv)
        else $error("walker advanced into a stalled output word");
`endif

endmodule

/* hw/rtl/bitmap_glyph_text_renderer.sv */
// Bitmap text renderer, 5x8 font: one character word in, one framebuffer write word
// per visible glyph pixel out. Input channel i_in_valid/o_in_ready carries the
// character with an optional new text origin; output channel o_out_valid/i_out_ready
// carries pixel_address (row * SCREEN_WIDTH + column), pixel_color and last_pixel.
// Pixels go out column by column, top to bottom; off-screen pixels are skipped, and
// last_pixel marks the final write of a character. A glyph entirely off screen gives
// no word. After each character the cursor moves right by 6, saturating at 1023.
// The first write of a character passes the setup register, the walker state and
// the output word. Throughput: one write per cycle unless the receiver stalls; the
// next character's first write follows its predecessor's last with no gap, as the
// setup register holds the next character while the walker works. The pace is
// set by the single output port fed from the font memory's one read port.
// A fully clipped character leaves the setup register without occupying the walker.
// Reset (synchronous, i_rst_n low) clears the cursor and line to 0 and drops all
// pending words. When the receiver stalls, the output word holds and the walker
// and font read freeze; input is still taken until the setup register fills.
module bitmap_glyph_text_renderer
    import bgtr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_start_of_text,
    input  logic signed [COORD_W-1:0] i_start_x,
    input  logic signed [COORD_W-1:0] i_start_y,
    input  logic [CODE_W-1:0]         i_char_code,
    input  logic [COLOR_W-1:0]        i_fg_color,
    input  logic [COLOR_W-1:0]        i_bg_color,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [ADDR_W-1:0]         o_pixel_address,
    output logic [COLOR_W-1:0]        o_pixel_color,
    output logic                      o_last_pixel
);

    localparam logic signed [COORD_W:0] STEP_E = (COORD_W+1)'(CURSOR_STEP);
    localparam logic signed [COORD_W:0] MAX_E  = (COORD_W+1)'(CURSOR_MAX);

    logic signed [COORD_W-1:0] r_cursor_x, r_line_y;
    logic signed [COORD_W-1:0] eff_x, eff_y;
    logic signed [COORD_W:0]   next_x;
    logic                      r_s_valid;
    t_setup                    r_s, n_s;
    logic                      in_acc, job_take;
    logic                      rom_en;
    logic [ROM_AW-1:0]         rom_addr;
    logic [7:0]                rom_data;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_s_valid || job_take;

    always_comb begin
        eff_x  = i_start_of_text ? i_start_x : r_cursor_x;
        eff_y  = i_start_of_text ? i_start_y : r_line_y;
        next_x = {eff_x[COORD_W-1], eff_x} + STEP_E;
        n_s.cx    = eff_x;
        n_s.cy    = eff_y;
        n_s.gbase = ROM_AW'(glyph_number(i_char_code)) * ROM_AW'(GLYPH_COLS);
        n_s.fg    = i_fg_color;
        n_s.bg    = i_bg_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_line_y   <= '0;
            r_s_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_cursor_x <= (next_x > MAX_E) ? COORD_W'(CURSOR_MAX) : next_x[COORD_W-1:0];
                r_line_y   <= eff_y;
                r_s_valid  <= 1'b1;
            end else if (job_take) begin
                r_s_valid  <= 1'b0;
            end
        end
        if (in_acc) begin
            r_s <= n_s;
        end
    end

    bgtr_font_rom u_font (
        .i_clk     (i_clk),
        .i_rd_en   (rom_en),
        .i_rd_addr (rom_addr),
        .o_rd_data (rom_data)
    );

    bgtr_pixel_walker #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_walker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (r_s_valid),
        .i_job           (r_s),
        .o_job_take      (job_take),
        .o_rom_en        (rom_en),
        .o_rom_addr      (rom_addr),
        .i_rom_data      (rom_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_last_pixel    (o_last_pixel)
    );

endmodule
